/* hdl/qtbe_pkg.sv */
`timescale 1ns / 1ps

package qtbe_pkg;

	// default width of one tensor component at the ports
	localparam int COMPONENT_WIDTH_DEF = 16;

	// internal component, signed Q3.16
	localparam int CI = 19;

	// strength register, unsigned Q4.12
	localparam int U_W = 16;
	localparam logic [U_W-1:0] U_RESET = 16'd12288;

	// result width, signed Q8.24
	localparam int OUT_W = 32;

endpackage

/* hdl/qtbe_norm.sv */
`timescale 1ns / 1ps

module qtbe_norm #(
	parameter int COMPONENT_WIDTH = qtbe_pkg::COMPONENT_WIDTH_DEF
) (
	input  logic signed [COMPONENT_WIDTH-1:0] raw,
	output logic signed [qtbe_pkg::CI-1:0]    value
);

	localparam int CI = qtbe_pkg::CI;
	localparam int UP = CI - 1 - COMPONENT_WIDTH;
	localparam int DN = COMPONENT_WIDTH - (CI - 1);

	generate
		if (COMPONENT_WIDTH <= CI - 1) begin : g_up
			assign value = CI'(raw) <<< UP;
		end else begin : g_dn
			// round to nearest, ties upward
			logic signed [COMPONENT_WIDTH:0] ext;
			logic signed [COMPONENT_WIDTH:0] rnd;
			assign ext = (COMPONENT_WIDTH + 1)'(raw);
			assign rnd = ext + $signed((COMPONENT_WIDTH + 1)'(1) << (DN - 1));
			assign value = CI'(rnd >>> DN);
		end
	endgenerate

endmodule

/* hdl/q_tensor_bulk_energy_unit.sv */
`timescale 1ns / 1ps
// Throughput: one lattice site per cycle while out_stall is low; each of the 12 stages holds one item and
// a stage takes a new item whenever it is empty or its content moves on.
// Reset (arst_n low, asynchronous): pipeline emptied, u_strength back to 3.0.
// Data registers are not reset.

module q_tensor_bulk_energy_unit #(
	parameter int COMPONENT_WIDTH = qtbe_pkg::COMPONENT_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [qtbe_pkg::U_W-1:0]            cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [COMPONENT_WIDTH-1:0]   q_xx,
	input  logic signed [COMPONENT_WIDTH-1:0]   q_xy,
	input  logic signed [COMPONENT_WIDTH-1:0]   q_xz,
	input  logic signed [COMPONENT_WIDTH-1:0]   q_yy,
	input  logic signed [COMPONENT_WIDTH-1:0]   q_yz,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [qtbe_pkg::OUT_W-1:0]   trace_square,
	output logic signed [qtbe_pkg::OUT_W-1:0]   trace_cube,
	output logic signed [qtbe_pkg::OUT_W-1:0]   energy_density
);

	localparam int NS    = 12;
	localparam int CI    = qtbe_pkg::CI;
	localparam int CZ    = CI + 1;
	localparam int U_W   = qtbe_pkg::U_W;
	localparam int OUT_W = qtbe_pkg::OUT_W;
	localparam int PW    = 2 * CI;
	localparam int PZ    = CI + CZ;
	localparam int SW    = PW + 3;
	localparam int CC    = PZ + 1;
	localparam int CL    = 20;
	localparam int DPW   = CI + CC - CL;
	localparam int DPL   = CI + CL + 1;
	localparam int SQW   = 2 * OUT_W;
	localparam int SQRW  = 40;
	localparam int DW    = 60;
	localparam int D3W   = DW + 2;
	localparam int T3W   = 36;
	localparam int IW    = 42;
	localparam int IL    = 20;
	localparam int PHW   = U_W + 1 + IW - IL;
	localparam int PLW   = U_W + IL;
	localparam int NW    = 60;
	localparam int ZW    = 34;
	localparam int ZLW   = 17;
	localparam int ZHW   = ZW - ZLW;
	localparam int QPW   = ZHW + 16;
	localparam int WW    = ZLW + 2;
	localparam int WPW   = WW + 18;

	localparam logic [15:0] DIV3_M17 = 16'd43691;
	localparam logic [17:0] DIV3_M19 = 18'd174763;
	localparam logic signed [NW-1:0] E_LIM = NW'(64'sd6442450944);
	localparam logic signed [OUT_W-1:0] SAT_MAX = {1'b0, {(OUT_W - 1){1'b1}}};
	localparam logic signed [OUT_W-1:0] SAT_MIN = {1'b1, {(OUT_W - 1){1'b0}}};

	// configuration
	logic [U_W-1:0] u_strength_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			u_strength_q <= qtbe_pkg::U_RESET;
		end else if (cfg_we) begin
			u_strength_q <= cfg_wdata;
		end
	end

	// valid chain
	logic [NS:1]   vld_q;
	logic [NS+1:1] adv;

	always_comb begin
		adv[NS+1] = !out_stall;
		for (int k = NS; k >= 1; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[1]) begin
				vld_q[1] <= in_valid;
			end
			for (int k = 2; k <= NS; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign in_stall  = !adv[1];
	assign out_valid = vld_q[NS];

	// stage 1: components to Q3.16
	logic signed [CI-1:0] n_xx, n_xy, n_xz, n_yy, n_yz;

	qtbe_norm #(.COMPONENT_WIDTH(COMPONENT_WIDTH)) u_norm_xx (.raw(q_xx), .value(n_xx));
	qtbe_norm #(.COMPONENT_WIDTH(COMPONENT_WIDTH)) u_norm_xy (.raw(q_xy), .value(n_xy));
	qtbe_norm #(.COMPONENT_WIDTH(COMPONENT_WIDTH)) u_norm_xz (.raw(q_xz), .value(n_xz));
	qtbe_norm #(.COMPONENT_WIDTH(COMPONENT_WIDTH)) u_norm_yy (.raw(q_yy), .value(n_yy));
	qtbe_norm #(.COMPONENT_WIDTH(COMPONENT_WIDTH)) u_norm_yz (.raw(q_yz), .value(n_yz));

	logic signed [CI-1:0] xx_s1, xy_s1, xz_s1, yy_s1, yz_s1;
	logic signed [CZ-1:0] zz_s1;

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			xx_s1 <= n_xx;
			xy_s1 <= n_xy;
			xz_s1 <= n_xz;
			yy_s1 <= n_yy;
			yz_s1 <= n_yz;
			zz_s1 <= -CZ'(n_xx) - CZ'(n_yy);
		end
	end

	// stage 2: pair products
	logic signed [PW-1:0] pxx_s2, pxy_s2, pxz_s2, pyy_s2, pyz_s2, pxxyy_s2;
	logic signed [PZ-1:0] pyyzz_s2, pxyzz_s2, pyzxz_s2, pxyyz_s2, pyyxz_s2;
	logic signed [CI-1:0] xx_s2, xy_s2, xz_s2;

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			pxx_s2   <= PW'(xx_s1) * PW'(xx_s1);
			pxy_s2   <= PW'(xy_s1) * PW'(xy_s1);
			pxz_s2   <= PW'(xz_s1) * PW'(xz_s1);
			pyy_s2   <= PW'(yy_s1) * PW'(yy_s1);
			pyz_s2   <= PW'(yz_s1) * PW'(yz_s1);
			pxxyy_s2 <= PW'(xx_s1) * PW'(yy_s1);
			pyyzz_s2 <= PZ'(yy_s1) * PZ'(zz_s1);
			pxyzz_s2 <= PZ'(xy_s1) * PZ'(zz_s1);
			pyzxz_s2 <= PZ'(yz_s1) * PZ'(xz_s1);
			pxyyz_s2 <= PZ'(xy_s1) * PZ'(yz_s1);
			pyyxz_s2 <= PZ'(yy_s1) * PZ'(xz_s1);
			xx_s2    <= xx_s1;
			xy_s2    <= xy_s1;
			xz_s2    <= xz_s1;
		end
	end

	// stage 3: trQ2 and cofactors
	logic signed [SW-1:0] sum_t2;

	always_comb begin
		sum_t2 = SW'(pxx_s2) + SW'(pxy_s2) + SW'(pxz_s2) + SW'(pyy_s2)
			+ SW'(pyz_s2) + SW'(pxxyy_s2);
	end

	logic signed [OUT_W-1:0] t2_s3;
	logic signed [CC-1:0]    c1_s3, c2_s3, c3_s3;
	logic signed [CI-1:0]    xx_s3, xy_s3, xz_s3;

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			t2_s3 <= OUT_W'((sum_t2 + SW'(64)) >>> 7);
			c1_s3 <= CC'(pyyzz_s2) - CC'(pyz_s2);
			c2_s3 <= CC'(pxyzz_s2) - CC'(pyzxz_s2);
			c3_s3 <= CC'(pxyyz_s2) - CC'(pyyxz_s2);
			xx_s3 <= xx_s2;
			xy_s3 <= xy_s2;
			xz_s3 <= xz_s2;
		end
	end

	// stage 4: determinant partial products, trQ2 squared
	logic signed [DPW-1:0]   pd1h_s4, pd2h_s4, pd3h_s4;
	logic signed [DPL-1:0]   pd1l_s4, pd2l_s4, pd3l_s4;
	logic signed [SQW-1:0]   t2sq_s4;
	logic signed [OUT_W-1:0] t2_s4;

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			pd1h_s4 <= DPW'(xx_s3) * DPW'($signed(c1_s3[CC-1:CL]));
			pd2h_s4 <= DPW'(xy_s3) * DPW'($signed(c2_s3[CC-1:CL]));
			pd3h_s4 <= DPW'(xz_s3) * DPW'($signed(c3_s3[CC-1:CL]));
			pd1l_s4 <= DPL'(xx_s3) * DPL'($signed({1'b0, c1_s3[CL-1:0]}));
			pd2l_s4 <= DPL'(xy_s3) * DPL'($signed({1'b0, c2_s3[CL-1:0]}));
			pd3l_s4 <= DPL'(xz_s3) * DPL'($signed({1'b0, c3_s3[CL-1:0]}));
			t2sq_s4 <= SQW'(t2_s3) * SQW'(t2_s3);
			t2_s4   <= t2_s3;
		end
	end

	// stage 5: determinant, rounded square
	logic signed [DW-1:0] hsum, lsum;

	always_comb begin
		hsum = DW'(pd1h_s4) - DW'(pd2h_s4) + DW'(pd3h_s4);
		lsum = DW'(pd1l_s4) - DW'(pd2l_s4) + DW'(pd3l_s4);
	end

	logic signed [DW-1:0]    det_s5;
	logic signed [SQRW-1:0]  sq_s5;
	logic signed [OUT_W-1:0] t2_s5;

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			det_s5 <= (hsum <<< CL) + lsum;
			sq_s5  <= SQRW'((t2sq_s4 + SQW'(2 ** 23)) >>> 24);
			t2_s5  <= t2_s4;
		end
	end

	// stage 6: trQ3 = 3 det, rounded
	logic signed [D3W-1:0] det3;

	always_comb begin
		det3 = D3W'(det_s5) + (D3W'(det_s5) <<< 1);
	end

	logic signed [T3W-1:0]   t3_s6;
	logic signed [SQRW-1:0]  sq_s6;
	logic signed [OUT_W-1:0] t2_s6;

	always_ff @(posedge clk) begin
		if (adv[6]) begin
			t3_s6 <= T3W'((det3 + D3W'(2 ** 23)) >>> 24);
			sq_s6 <= sq_s5;
			t2_s6 <= t2_s5;
		end
	end

	// stage 7: 3 sq - 2 t2 - 4 t3, clamp trQ3
	logic signed [IW-1:0]    inner_s7;
	logic signed [OUT_W-1:0] t2_s7, t3o_s7;

	always_ff @(posedge clk) begin
		if (adv[7]) begin
			inner_s7 <= IW'(sq_s6) + (IW'(sq_s6) <<< 1) - (IW'(t2_s6) <<< 1)
				- (IW'(t3_s6) <<< 2);
			if (t3_s6[T3W-1:OUT_W-1] == '0 || t3_s6[T3W-1:OUT_W-1] == '1) begin
				t3o_s7 <= OUT_W'(t3_s6);
			end else begin
				t3o_s7 <= t3_s6[T3W-1] ? SAT_MIN : SAT_MAX;
			end
			t2_s7 <= t2_s6;
		end
	end

	// stage 8: U times inner, split in two halves
	logic signed [PHW-1:0]   puh_s8;
	logic        [PLW-1:0]   pul_s8;
	logic signed [OUT_W-1:0] t2_s8, t3o_s8;

	always_ff @(posedge clk) begin
		if (adv[8]) begin
			puh_s8 <= PHW'($signed({1'b0, u_strength_q})) * PHW'($signed(inner_s7[IW-1:IL]));
			pul_s8 <= PLW'(u_strength_q) * PLW'(inner_s7[IL-1:0]);
			t2_s8  <= t2_s7;
			t3o_s8 <= t3o_s7;
		end
	end

	// stage 9: 12 * 2^12 * E numerator
	logic signed [NW-1:0]    num_s9;
	logic signed [OUT_W-1:0] t2_s9, t3o_s9;

	always_ff @(posedge clk) begin
		if (adv[9]) begin
			num_s9 <= (NW'(puh_s8) <<< IL) + $signed(NW'(pul_s8))
				+ ((NW'(t2_s8) + (NW'(t2_s8) <<< 1)) <<< 13);
			t2_s9  <= t2_s8;
			t3o_s9 <= t3o_s8;
		end
	end

	// stage 10: round by 2^14, range check, bias for the divide by 3
	logic signed [NW-1:0] y_e, z_e;

	always_comb begin
		y_e = (num_s9 + NW'(24576)) >>> 14;
		z_e = y_e + E_LIM;
	end

	logic [ZHW-1:0]          zh_s10;
	logic [ZLW-1:0]          zl_s10;
	logic                    sat_hi_s10, sat_lo_s10;
	logic signed [OUT_W-1:0] t2_s10, t3o_s10;

	always_ff @(posedge clk) begin
		if (adv[10]) begin
			zh_s10     <= z_e[ZW-1:ZLW];
			zl_s10     <= z_e[ZLW-1:0];
			sat_hi_s10 <= y_e >= E_LIM;
			sat_lo_s10 <= y_e < -E_LIM;
			t2_s10     <= t2_s9;
			t3o_s10    <= t3o_s9;
		end
	end

	// stage 11: high digit of z / 3
	logic [QPW-1:0] qprod;
	logic [15:0]    qh;
	logic [ZHW-1:0] rfull;

	always_comb begin
		qprod = QPW'(zh_s10) * QPW'(DIV3_M17);
		qh    = qprod[QPW-1:ZHW];
		rfull = zh_s10 - ZHW'(qh) - (ZHW'(qh) << 1);
	end

	logic [14:0]             qh_s11;
	logic [1:0]              rh_s11;
	logic [ZLW-1:0]          zl_s11;
	logic                    sat_hi_s11, sat_lo_s11;
	logic signed [OUT_W-1:0] t2_s11, t3o_s11;

	always_ff @(posedge clk) begin
		if (adv[11]) begin
			qh_s11     <= qh[14:0];
			rh_s11     <= rfull[1:0];
			zl_s11     <= zl_s10;
			sat_hi_s11 <= sat_hi_s10;
			sat_lo_s11 <= sat_lo_s10;
			t2_s11     <= t2_s10;
			t3o_s11    <= t3o_s10;
		end
	end

	// stage 12: low digit of z / 3, remove bias, clamp
	logic [WW-1:0]           wval;
	logic [WPW-1:0]          wprod;
	logic [ZLW-1:0]          qw;
	logic signed [OUT_W-1:0] e_raw;

	always_comb begin
		wval  = {rh_s11, zl_s11};
		wprod = WPW'(wval) * WPW'(DIV3_M19);
		qw    = wprod[WPW-2:WW];
		e_raw = {~qh_s11[14], qh_s11[13:0], qw};
	end

	logic signed [OUT_W-1:0] t2_s12, t3o_s12, e_s12;

	always_ff @(posedge clk) begin
		if (adv[12]) begin
			priority if (sat_hi_s11) begin
				e_s12 <= SAT_MAX;
			end else if (sat_lo_s11) begin
				e_s12 <= SAT_MIN;
			end else begin
				e_s12 <= e_raw;
			end
			t2_s12  <= t2_s11;
			t3o_s12 <= t3o_s11;
		end
	end

	assign trace_square   = t2_s12;
	assign trace_cube     = t3o_s12;
	assign energy_density = e_s12;

`ifndef ASSERT_OFF
	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> vld_q[1])
		else $error("accepted transfer did not reach first stage");

	a_free_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled while output is free");

	a_square_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !trace_square[OUT_W-1])
		else $error("negative trace of Q squared");
`endif

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

	localparam int CW = qtbe_pkg::COMPONENT_WIDTH_DEF;
	localparam int OUT_W = qtbe_pkg::OUT_W;
	localparam int U_W = qtbe_pkg::U_W;
	localparam int FRAC_UP = 16 - (CW - 2);
	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_PER_PHASE = 300;
	localparam int N_PHASES = 6;
	localparam int N_DIRECTED = 16;
	localparam longint S32_MAX = 64'sd2147483647;
	localparam longint S32_MIN = -64'sd2147483648;

	typedef struct packed {
		logic signed [CW-1:0] xx;
		logic signed [CW-1:0] xy;
		logic signed [CW-1:0] xz;
		logic signed [CW-1:0] yy;
		logic signed [CW-1:0] yz;
	} site_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] tsq;
		logic signed [OUT_W-1:0] tcube;
		logic signed [OUT_W-1:0] energy;
	} site_result_t;

	typedef struct packed {
		site_t site;
		logic known;
		site_result_t want;
	} directed_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [U_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [CW-1:0] q_xx = '0;
	logic signed [CW-1:0] q_xy = '0;
	logic signed [CW-1:0] q_xz = '0;
	logic signed [CW-1:0] q_yy = '0;
	logic signed [CW-1:0] q_yz = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [OUT_W-1:0] trace_square;
	logic signed [OUT_W-1:0] trace_cube;
	logic signed [OUT_W-1:0] energy_density;

	// sideband travelling with the payload: typed-in expectation for directed rows
	logic row_known = 1'b0;
	site_result_t row_want = '0;

	site_result_t pending_results[$];
	logic [U_W-1:0] u_now = qtbe_pkg::U_RESET;
	int failures = 0;
	int idle_cycles = 0;
	int stall_mode = 0;
	int stall_run = 0;

	directed_row_t directed_rows [N_DIRECTED] = '{
		'{'{0, 0, 0, 0, 0}, 1'b1, '{0, 0, 0}},
		'{'{8192, 0, 0, 0, 0}, 1'b1, '{8388608, 0, 3145728}},
		'{'{-8192, 0, 0, 0, 0}, 1'b1, '{8388608, 0, 3145728}},
		'{'{-32768, -32768, -32768, -32768, -32768}, 1'b0, '0},
		'{'{32767, 32767, 32767, 32767, 32767}, 1'b0, '0},
		'{'{32767, 0, 0, 32767, 0}, 1'b0, '0},
		'{'{-32768, 32767, -32768, -32768, 32767}, 1'b0, '0},
		'{'{0, -32768, 0, 0, 0}, 1'b0, '0},
		'{'{0, 0, 32767, 0, 0}, 1'b0, '0},
		'{'{0, 0, 0, 0, -32768}, 1'b0, '0},
		'{'{-4096, 0, 0, -4096, 0}, 1'b0, '0},
		'{'{21845, -21846, 21845, -21846, 21845}, 1'b0, '0},
		'{'{1, 0, 0, 0, 0}, 1'b0, '0},
		'{'{-1, -1, -1, -1, -1}, 1'b0, '0},
		'{'{3000, -2000, 1500, -4000, 2500}, 1'b0, '0},
		'{'{8, 8, -8, 0, 8}, 1'b0, '0}
	};

	q_tensor_bulk_energy_unit #(
		.COMPONENT_WIDTH(CW)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.q_xx(q_xx),
		.q_xy(q_xy),
		.q_xz(q_xz),
		.q_yy(q_yy),
		.q_yz(q_yz),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.trace_square(trace_square),
		.trace_cube(trace_cube),
		.energy_density(energy_density)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// nearest, ties toward plus infinity
	function automatic longint round_div(longint x, longint d);
		longint y;
		longint q;
		y = x + d / 2;
		q = y / d;
		if (y % d != 0 && y < 0)
			q--;
		return q;
	endfunction

	function automatic logic signed [OUT_W-1:0] clamp32(longint x);
		if (x > S32_MAX)
			return S32_MAX[OUT_W-1:0];
		if (x < S32_MIN)
			return S32_MIN[OUT_W-1:0];
		return x[OUT_W-1:0];
	endfunction

	// component to 16 fraction bits
	function automatic longint widen(logic signed [CW-1:0] c);
		longint v;
		v = c;
		return v * (64'sd1 << FRAC_UP);
	endfunction

	function automatic site_result_t bulk_energy_of(site_t s, logic [U_W-1:0] u);
		longint xx, xy, xz, yy, yz, zz;
		longint t2raw, det, t2, t3, sq, inner, num, e;
		site_result_t r;
		xx = widen(s.xx);
		xy = widen(s.xy);
		xz = widen(s.xz);
		yy = widen(s.yy);
		yz = widen(s.yz);
		zz = -xx - yy;
		t2raw = 2 * (xx * xx + xy * xy + xz * xz + yy * yy + yz * yz + xx * yy);
		det = xx * (yy * zz - yz * yz) - xy * (xy * zz - yz * xz) + xz * (xy * yz - yy * xz);
		t2 = round_div(t2raw, 64'sd1 << 8);
		t3 = round_div(3 * det, 64'sd1 << 24);
		sq = round_div(t2 * t2, 64'sd1 << 24);
		// 12 * 2^12 * E = 6 * 2^12 * T2 + U * (3*T2^2 - 2*T2 - 4*T3)
		inner = 3 * sq - 2 * t2 - 4 * t3;
		num = 6 * 4096 * t2 + longint'(u) * inner;
		e = round_div(num, 12 * 4096);
		r.tsq = clamp32(t2);
		r.tcube = clamp32(t3);
		r.energy = clamp32(e);
		return r;
	endfunction

	function automatic logic signed [CW-1:0] random_component(int kind);
		if (kind < 5)
			return CW'($urandom);
		if (kind < 8)
			return CW'(int'($urandom_range(0, 16384)) - 8192);
		if ($urandom_range(0, 1) == 0)
			return CW'($urandom);
		unique case ($urandom_range(0, 4))
			0: return CW'(-32768);
			1: return CW'(32767);
			2: return CW'(0);
			3: return CW'(-1);
			default: return CW'(1);
		endcase
	endfunction

	function automatic site_t random_site();
		site_t s;
		int kind;
		kind = $urandom_range(0, 9);
		s.xx = random_component(kind);
		s.xy = random_component(kind);
		s.xz = random_component(kind);
		s.yy = random_component(kind);
		s.yz = random_component(kind);
		return s;
	endfunction

	task automatic push_site(site_t s, logic known, site_result_t want);
		in_valid <= 1'b1;
		q_xx <= s.xx;
		q_xy <= s.xy;
		q_xz <= s.xz;
		q_yy <= s.yy;
		q_yz <= s.yz;
		row_known <= known;
		row_want <= want;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic idle_gap(int n);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_strength(logic [U_W-1:0] v);
		drain_results();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_random(int n);
		int sent;
		int burst;
		int gap_max;
		sent = 0;
		while (sent < n) begin
			burst = $urandom_range(1, 48);
			gap_max = ($urandom_range(0, 3) == 0) ? 0 : 20;
			for (int i = 0; i < burst && sent < n; i++) begin
				push_site(random_site(), 1'b0, '0);
				sent++;
			end
			if ($urandom_range(0, 29) == 0)
				drain_results();
			else
				idle_gap($urandom_range(0, gap_max));
		end
	endtask

	// receiver stall pattern: free run, light, heavy, and regular long stalls
	always @(posedge clk) begin
		if (stall_run == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_run = $urandom_range(20, 200);
		end else begin
			stall_run = stall_run - 1;
		end
		unique case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 1) == 0);
			default: out_stall <= ((stall_run % 16) < 11);
		endcase
	end

	always @(posedge clk) begin
		site_result_t got, want;
		logic [2:0][OUT_W-1:0] got_v, want_v;
		string field_names [3];
		logic moved;
		field_names = '{"energy_density", "trace_cube", "trace_square"};
		moved = 1'b0;
		if (arst_n) begin
			if (cfg_we) begin
				u_now = cfg_wdata;
				moved = 1'b1;
			end
			if (in_valid && !in_stall) begin
				moved = 1'b1;
				if (row_known)
					pending_results.push_back(row_want);
				else
					pending_results.push_back(bulk_energy_of(
						site_t'{q_xx, q_xy, q_xz, q_yy, q_yz}, u_now));
			end
			if (out_valid && !out_stall) begin
				moved = 1'b1;
				got = '{trace_square, trace_cube, energy_density};
				if (pending_results.size() == 0) begin
					failures++;
					if (failures <= 10)
						$display("%0t: unexpected result %0d %0d %0d", $realtime,
							trace_square, trace_cube, energy_density);
				end else begin
					want = pending_results.pop_front();
					got_v = got;
					want_v = want;
					for (int i = 0; i < 3; i++) begin
						if (got_v[i] !== want_v[i]) begin
							failures++;
							if (failures <= 10)
								$display("%0t: %s expected %0d got %0d", $realtime,
									field_names[i], $signed(want_v[i]), $signed(got_v[i]));
						end
					end
				end
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
		end
	end

	initial begin
		while (idle_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("q_tensor_bulk_energy_unit test failed");
		$finish;
	end

	initial begin
		logic [U_W-1:0] plan [N_PHASES];
		plan = '{16'd0, 16'hFFFF, 16'd4096, 16'd1, 16'd0, qtbe_pkg::U_RESET};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++) begin
			push_site(directed_rows[i].site, directed_rows[i].known, directed_rows[i].want);
			idle_gap($urandom_range(0, 3));
		end

		for (int p = 0; p < N_PHASES; p++) begin
			set_strength((p == 4) ? U_W'($urandom) : plan[p]);
			run_random(RANDOM_PER_PHASE);
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		if (failures == 0 && pending_results.size() == 0) begin
			$display("q_tensor_bulk_energy_unit test passed");
		end else begin
			$display("q_tensor_bulk_energy_unit test failed");
		end
		$finish;
	end

endmodule
